FILE: rtl/core/erqm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erqm_pkg
// Shared widths, codes, types and helpers of the round-robin queue merge.
// ----------------------------------------------------------------------------
package erqm_pkg;

   // Sizes of the queue set
   localparam int NODES        = 8;
   localparam int DEPTH        = 64;
   localparam int PAYLOAD_BITS = 32;

   // Derived widths
   localparam int QW   = $clog2(NODES);      // queue index
   localparam int PW   = $clog2(DEPTH);      // ring pointer
   localparam int AW   = QW + PW;            // entry memory address
   localparam int EW   = PAYLOAD_BITS + 1;   // marker bit above payload
   localparam int NCW  = 4;                  // node_count register
   localparam int LNW  = 3;                  // local_node register
   localparam int LENW = 7;                  // queue_entries register
   localparam int STW  = 3;                  // status code
   localparam int EPW  = 32;                 // epoch counter

   // Configuration port
   localparam int CSR_AW = 4;
   localparam int CSR_DW = 32;

   // Register indexes
   typedef enum logic [1:0] {
      REG_NODE_COUNT    = 2'd0,
      REG_LOCAL_NODE    = 2'd1,
      REG_QUEUE_ENTRIES = 2'd2
   } reg_index_type;

   // Operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Result status codes
   localparam logic [STW-1:0] ST_ENQUEUED = 3'd0;
   localparam logic [STW-1:0] ST_FULL     = 3'd1;
   localparam logic [STW-1:0] ST_MESSAGE  = 3'd2;
   localparam logic [STW-1:0] ST_MARKER   = 3'd3;
   localparam logic [STW-1:0] ST_EMPTY    = 3'd4;
   localparam logic [STW-1:0] ST_BAD_QUEUE = 3'd5;

   // Configuration seen by the controller
   typedef struct packed {
      logic [NCW-1:0]  node_count;
      logic [LNW-1:0]  local_node;
      logic [LENW-1:0] queue_entries;
   } cfg_type;

   // Request to the entry memory
   typedef struct packed {
      logic          we;
      logic          re;
      logic [AW-1:0] addr;
      logic [EW-1:0] wdata;
   } mem_req_type;

   // One result item
   typedef struct packed {
      logic [STW-1:0]          status;
      logic [PAYLOAD_BITS-1:0] payload_out;
      logic [QW-1:0]           source_queue;
      logic                    from_remote;
      logic                    epoch_advanced;
      logic [EPW-1:0]          epoch;
   } rsp_type;

   // Ring pointer increment, wrapping at the ring length
   function automatic logic [PW-1:0] next_idx(input logic [PW-1:0] idx,
                                              input logic [LENW-1:0] len);
      logic [LENW-1:0] n;
      n = LENW'(idx) + LENW'(1);
      return (n >= len) ? '0 : n[PW-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/erqm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erqm_if
// Valid/ready channels for request and response items.
// ----------------------------------------------------------------------------
interface erqm_req_if;
   logic                              valid;
   logic                              ready;
   logic                              operation;
   logic [erqm_pkg::QW-1:0]           queue_id;
   logic                              is_end_marker;
   logic [erqm_pkg::PAYLOAD_BITS-1:0] payload;

   modport source (output valid, operation, queue_id, is_end_marker, payload,
                   input ready);
   modport sink   (input valid, operation, queue_id, is_end_marker, payload,
                   output ready);
endinterface

interface erqm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [erqm_pkg::STW-1:0]          status;
   logic [erqm_pkg::PAYLOAD_BITS-1:0] payload_out;
   logic [erqm_pkg::QW-1:0]           source_queue;
   logic                              from_remote;
   logic                              epoch_advanced;
   logic [erqm_pkg::EPW-1:0]          epoch;

   modport source (output valid, status, payload_out, source_queue, from_remote,
                          epoch_advanced, epoch,
                   input ready);
   modport sink   (input valid, status, payload_out, source_queue, from_remote,
                         epoch_advanced, epoch,
                   output ready);
endinterface
`default_nettype wire

FILE: rtl/core/erqm_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erqm_csr
// APB register file: node count, local node and ring length.
// ----------------------------------------------------------------------------
module erqm_csr (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [erqm_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [erqm_pkg::CSR_DW-1:0]  pwdata,
   output      logic [erqm_pkg::CSR_DW-1:0]  prdata,
   output      logic                         pready,
   output      erqm_pkg::cfg_type            cfg
);

   erqm_pkg::cfg_type       cfg_ff, cfg_in;
   erqm_pkg::reg_index_type reg_idx;
   logic                    wr_en;

   assign pready  = 1'b1;
   assign reg_idx = erqm_pkg::reg_index_type'(paddr[3:2]);
   assign wr_en   = psel && penable && pwrite;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            erqm_pkg::REG_NODE_COUNT:
               cfg_in.node_count = pwdata[erqm_pkg::NCW-1:0];
            erqm_pkg::REG_LOCAL_NODE:
               cfg_in.local_node = pwdata[erqm_pkg::LNW-1:0];
            erqm_pkg::REG_QUEUE_ENTRIES:
               cfg_in.queue_entries = pwdata[erqm_pkg::LENW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.node_count    <= erqm_pkg::NCW'(1);
         cfg_ff.local_node    <= '0;
         cfg_ff.queue_entries <= erqm_pkg::LENW'(erqm_pkg::DEPTH);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back
   always_comb begin
      unique case (reg_idx)
         erqm_pkg::REG_NODE_COUNT:
            prdata = erqm_pkg::CSR_DW'(cfg_ff.node_count);
         erqm_pkg::REG_LOCAL_NODE:
            prdata = erqm_pkg::CSR_DW'(cfg_ff.local_node);
         erqm_pkg::REG_QUEUE_ENTRIES:
            prdata = erqm_pkg::CSR_DW'(cfg_ff.queue_entries);
         default:
            prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: rtl/core/erqm_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erqm_store
// Entry memory of all rings: one write and one read per cycle, registered read.
// ----------------------------------------------------------------------------
module erqm_store (
   input  wire logic                     clock,
   input  wire erqm_pkg::mem_req_type    mem_req,
   output      logic [erqm_pkg::EW-1:0]  rd_data
);

   localparam int ENTRIES = erqm_pkg::NODES * erqm_pkg::DEPTH;

   logic [erqm_pkg::EW-1:0] entry_mem [ENTRIES];
   logic [erqm_pkg::EW-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         entry_mem[mem_req.addr] <= mem_req.wdata;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (mem_req.re) begin
         rd_data_ff <= entry_mem[mem_req.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/core/erqm_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// erqm_ctrl
// Ring pointers, current queue, epoch counter and the item sequencer.
// ----------------------------------------------------------------------------
module erqm_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire erqm_pkg::cfg_type        cfg,
   erqm_req_if.sink                      req,
   erqm_rsp_if.source                    rsp,
   output      erqm_pkg::mem_req_type    mem_req,
   input  wire logic [erqm_pkg::EW-1:0]  rd_data
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_READ = 2'b10
   } state_type;

   localparam int QW   = erqm_pkg::QW;
   localparam int PW   = erqm_pkg::PW;
   localparam int NCW  = erqm_pkg::NCW;
   localparam int LENW = erqm_pkg::LENW;

   state_type          state_ff, state_in;
   logic [PW-1:0]      head_ff [erqm_pkg::NODES];
   logic [PW-1:0]      tail_ff [erqm_pkg::NODES];
   logic [QW-1:0]      cur_ff, cur_in;
   logic [erqm_pkg::EPW-1:0] epoch_ff, epoch_in;
   logic [QW-1:0]      rd_q_ff, rd_q_in;
   logic               rsp_valid_ff, rsp_valid_in;
   erqm_pkg::rsp_type  rsp_ff, rsp_in;

   logic [NCW-1:0]     nodes_eff;
   logic [LENW-1:0]    len_eff;
   logic [QW-1:0]      cur_eff;
   logic [QW-1:0]      q_sel;
   logic [PW-1:0]      head_q, tail_q, head_nxt, tail_nxt;
   logic               out_free, accept;
   logic               tail_we, head_we;

   // Clamped configuration
   always_comb begin
      if (cfg.node_count == '0) begin
         nodes_eff = NCW'(1);
      end else if (cfg.node_count > NCW'(erqm_pkg::NODES)) begin
         nodes_eff = NCW'(erqm_pkg::NODES);
      end else begin
         nodes_eff = cfg.node_count;
      end
      if (cfg.queue_entries < LENW'(2)) begin
         len_eff = LENW'(2);
      end else if (cfg.queue_entries > LENW'(erqm_pkg::DEPTH)) begin
         len_eff = LENW'(erqm_pkg::DEPTH);
      end else begin
         len_eff = cfg.queue_entries;
      end
   end

   // Queue under access and its pointers
   assign cur_eff  = (NCW'(cur_ff) >= nodes_eff) ? '0 : cur_ff;
   assign q_sel    = (req.operation == erqm_pkg::OP_DEQUEUE) ? cur_eff : req.queue_id;
   assign head_q   = head_ff[q_sel];
   assign tail_q   = tail_ff[q_sel];
   assign head_nxt = erqm_pkg::next_idx(head_q, len_eff);
   assign tail_nxt = erqm_pkg::next_idx(tail_q, len_eff);

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (state_ff == S_IDLE) && out_free;
   assign accept    = req.valid && req.ready;

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      epoch_in     = epoch_ff;
      rd_q_in      = rd_q_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_in       = rsp_ff;
      tail_we      = 1'b0;
      head_we      = 1'b0;
      mem_req      = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in                = '0;
               rsp_in.epoch          = epoch_ff;
               if (req.operation == erqm_pkg::OP_ENQUEUE) begin
                  rsp_valid_in = 1'b1;
                  if (NCW'(req.queue_id) >= nodes_eff) begin
                     rsp_in.status = erqm_pkg::ST_BAD_QUEUE;
                  end else if (tail_nxt == head_q) begin
                     rsp_in.status = erqm_pkg::ST_FULL;
                  end else begin
                     rsp_in.status = erqm_pkg::ST_ENQUEUED;
                     tail_we       = 1'b1;
                     mem_req.we    = 1'b1;
                     mem_req.addr  = {req.queue_id, tail_q};
                     mem_req.wdata = {req.is_end_marker, req.payload};
                  end
               end else begin
                  cur_in = cur_eff;
                  if (head_q == tail_q) begin
                     rsp_valid_in        = 1'b1;
                     rsp_in.status       = erqm_pkg::ST_EMPTY;
                     rsp_in.source_queue = cur_eff;
                  end else begin
                     // pop: read the head entry, finish in S_READ when out_free
                     head_we      = 1'b1;
                     mem_req.re   = 1'b1;
                     mem_req.addr = {cur_eff, head_q};
                     rd_q_in      = cur_eff;
                     state_in     = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in              = '0;
               rsp_in.source_queue = rd_q_ff;
               if (rd_data[erqm_pkg::PAYLOAD_BITS]) begin
                  // end marker: move to the next queue, close epoch on wrap
                  rsp_in.status = erqm_pkg::ST_MARKER;
                  if (NCW'(rd_q_ff) + NCW'(1) >= nodes_eff) begin
                     cur_in                = '0;
                     epoch_in              = epoch_ff + erqm_pkg::EPW'(1);
                     rsp_in.epoch_advanced = 1'b1;
                     rsp_in.epoch          = epoch_ff + erqm_pkg::EPW'(1);
                  end else begin
                     cur_in       = rd_q_ff + QW'(1);
                     rsp_in.epoch = epoch_ff;
                  end
               end else begin
                  rsp_in.status      = erqm_pkg::ST_MESSAGE;
                  rsp_in.payload_out = rd_data[erqm_pkg::PAYLOAD_BITS-1:0];
                  rsp_in.from_remote = (rd_q_ff != cfg.local_node);
                  rsp_in.epoch       = epoch_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cur_ff       <= '0;
         epoch_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < erqm_pkg::NODES; i++) begin
            head_ff[i] <= '0;
            tail_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         epoch_ff     <= epoch_in;
         rsp_valid_ff <= rsp_valid_in;
         if (tail_we) begin
            tail_ff[q_sel] <= tail_nxt;
         end
         if (head_we) begin
            head_ff[q_sel] <= head_nxt;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_q_ff <= rd_q_in;
      rsp_ff  <= rsp_in;
   end

   // Response channel
   assign rsp.valid          = rsp_valid_ff;
   assign rsp.status         = rsp_ff.status;
   assign rsp.payload_out    = rsp_ff.payload_out;
   assign rsp.source_queue   = rsp_ff.source_queue;
   assign rsp.from_remote    = rsp_ff.from_remote;
   assign rsp.epoch_advanced = rsp_ff.epoch_advanced;
   assign rsp.epoch          = rsp_ff.epoch;

endmodule
`default_nettype wire

FILE: rtl/core/epoch_round_robin_queue_merge.sv
`default_nettype none
// ----------------------------------------------------------------------------
// epoch_round_robin_queue_merge
// Round-robin merge of per-source ring queues with end-of-batch markers.
// ----------------------------------------------------------------------------
// One request item gives exactly one response item. An enqueue, a bad queue
// id, a full queue and a dequeue of an empty current queue load the response
// register at the accept edge. A dequeue that pops an entry goes through the
// registered read of the shared entry memory and the S_READ state; the
// pointer update happens at accept and the marker/message decision in S_READ
// once the response register is free. A new request is taken once the
// response register is empty or being drained in the same cycle, and never
// while a pop is in S_READ. There is no clearing pass after reset: entries
// are only read after being written.
// ----------------------------------------------------------------------------
module epoch_round_robin_queue_merge (
   input  wire logic                         clock,
   input  wire logic                         reset,
   erqm_req_if.sink                          req,
   erqm_rsp_if.source                        rsp,
   input  wire logic                         psel,
   input  wire logic                         penable,
   input  wire logic                         pwrite,
   input  wire logic [erqm_pkg::CSR_AW-1:0]  paddr,
   input  wire logic [erqm_pkg::CSR_DW-1:0]  pwdata,
   output      logic [erqm_pkg::CSR_DW-1:0]  prdata,
   output      logic                         pready
);

   erqm_pkg::cfg_type       cfg;
   erqm_pkg::mem_req_type   mem_req;
   logic [erqm_pkg::EW-1:0] rd_data;

   // Configuration registers
   erqm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Pointers and sequencer
   erqm_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .req     (req),
      .rsp     (rsp),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   // Entry memory
   erqm_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
`default_nettype wire

FILE: tb/tb_epoch_round_robin_queue_merge.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epoch_round_robin_queue_merge
// Self-checking bench for the round-robin queue merge: a directed opening
// walks full, bad queue, empty, marker, epoch wrap and current-pointer reset
// cases, then several register settings get random enqueue/dequeue traffic.
// Every accepted request is run through a behavioral model of the queue set
// and each response item is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb_epoch_round_robin_queue_merge;

   localparam int QW           = erqm_pkg::QW;
   localparam int PAYLOAD_BITS = erqm_pkg::PAYLOAD_BITS;
   localparam int EW           = erqm_pkg::EW;
   localparam int NODES        = erqm_pkg::NODES;
   localparam int DEPTH        = erqm_pkg::DEPTH;
   localparam int EPW          = erqm_pkg::EPW;
   localparam int CSR_AW       = erqm_pkg::CSR_AW;
   localparam int CSR_DW       = erqm_pkg::CSR_DW;
   localparam int NCW          = erqm_pkg::NCW;
   localparam int LNW          = erqm_pkg::LNW;
   localparam int LENW         = erqm_pkg::LENW;

   // One request item
   typedef struct packed {
      logic                    operation;
      logic [QW-1:0]           queue_id;
      logic                    is_end_marker;
      logic [PAYLOAD_BITS-1:0] payload;
   } req_item_type;

   logic clock;
   logic reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic              pready;

   erqm_req_if req_if ();
   erqm_rsp_if rsp_if ();

   epoch_round_robin_queue_merge DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_if),
      .rsp     (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Model of the queue set and its registers
   logic [EW-1:0]  ring_mem [NODES][DEPTH];
   int             ring_head [NODES];
   int             ring_tail [NODES];
   int             rr_cur;
   logic [EPW-1:0] epoch_ctr;
   int             cfg_nodes;
   int             cfg_local;
   int             cfg_len;

   req_item_type      queued_requests [$];
   erqm_pkg::rsp_type results_due [$];

   int  n_issued;
   int  n_accepted;
   int  n_results;
   int  error_count;
   int  seen_status [8];
   int  settings_used;
   int  long_holds;
   logic req_taken;

   // Sender burst state and receiver stall state
   int burst_left;
   int gap_left;
   int rx_cycle;
   int stall_pct;
   int hold_left;

   // Register settings of the random phases
   int phase_nodes [7] = '{3, 8, 1, 15, 0, 5, 8};
   int phase_local [7] = '{2, 7, 0, 5, 3, 4, 6};
   int phase_len   [7] = '{4, 64, 2, 127, 1, 6, 3};

   // Clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Known values on every input from time zero
   initial begin
      req_if.valid         = 1'b0;
      req_if.operation     = erqm_pkg::OP_ENQUEUE;
      req_if.queue_id      = '0;
      req_if.is_end_marker = 1'b0;
      req_if.payload       = '0;
      rsp_if.ready         = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_taken = 1'b0;
      n_issued = 0;
      n_accepted = 0;
      n_results = 0;
      error_count = 0;
      settings_used = 0;
      long_holds = 0;
      burst_left = 1;
      gap_left = 0;
      rx_cycle = 0;
      stall_pct = 0;
      hold_left = 0;
      foreach (seen_status[i]) seen_status[i] = 0;
      foreach (ring_head[i]) begin
         ring_head[i] = 0;
         ring_tail[i] = 0;
      end
      rr_cur = 0;
      epoch_ctr = '0;
      cfg_nodes = 1;
      cfg_local = 0;
      cfg_len = 64;
   end

   // Effective register values, clamped as the block does
   function automatic int active_nodes();
      if (cfg_nodes < 1) return 1;
      if (cfg_nodes > NODES) return NODES;
      return cfg_nodes;
   endfunction

   function automatic int ring_len();
      if (cfg_len < 2) return 2;
      if (cfg_len > DEPTH) return DEPTH;
      return cfg_len;
   endfunction

   function automatic int ring_step(input int idx);
      return (idx + 1 >= ring_len()) ? 0 : idx + 1;
   endfunction

   function automatic bit queues_busy();
      for (int i = 0; i < NODES; i++)
         if (ring_head[i] != ring_tail[i]) return 1'b1;
      return 1'b0;
   endfunction

   // Work out the response of one accepted request and queue it
   task automatic merge_predict(input req_item_type it);
      erqm_pkg::rsp_type r;
      int                nodes;
      int                q;
      logic [EW-1:0]     ent;
      nodes = active_nodes();
      r = '0;
      if (it.operation == erqm_pkg::OP_ENQUEUE) begin
         q = it.queue_id;
         if (q >= nodes) begin
            r.status = erqm_pkg::ST_BAD_QUEUE;
         end else if (ring_step(ring_tail[q]) == ring_head[q]) begin
            r.status = erqm_pkg::ST_FULL;
         end else begin
            ring_mem[q][ring_tail[q]] = {it.is_end_marker, it.payload};
            ring_tail[q] = ring_step(ring_tail[q]);
            r.status = erqm_pkg::ST_ENQUEUED;
         end
      end else begin
         if (rr_cur >= nodes) rr_cur = 0;
         q = rr_cur;
         r.source_queue = QW'(q);
         if (ring_head[q] == ring_tail[q]) begin
            r.status = erqm_pkg::ST_EMPTY;
         end else begin
            ent = ring_mem[q][ring_head[q]];
            ring_head[q] = ring_step(ring_head[q]);
            if (ent[PAYLOAD_BITS]) begin
               r.status = erqm_pkg::ST_MARKER;
               if (q == nodes - 1) begin
                  epoch_ctr = epoch_ctr + EPW'(1);
                  r.epoch_advanced = 1'b1;
               end
               rr_cur = (q + 1 >= nodes) ? 0 : q + 1;
            end else begin
               r.status = erqm_pkg::ST_MESSAGE;
               r.payload_out = ent[PAYLOAD_BITS-1:0];
               r.from_remote = (q != cfg_local);
            end
         end
      end
      r.epoch = epoch_ctr;
      results_due.push_back(r);
   endtask

   // One line per mismatch
   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      error_count++;
      $display("[%0t] response %0d: %s is %0h, model says %0h",
               $realtime, n_results, what, got, want);
   endtask

   task automatic check_result();
      erqm_pkg::rsp_type want;
      n_results++;
      if (rsp_if.status <= erqm_pkg::ST_BAD_QUEUE) seen_status[rsp_if.status]++;
      if (results_due.size() == 0) begin
         report_mismatch("unrequested response, status", rsp_if.status, '0);
      end else begin
         want = results_due.pop_front();
         if (rsp_if.status !== want.status)
            report_mismatch("status", rsp_if.status, want.status);
         if (rsp_if.payload_out !== want.payload_out)
            report_mismatch("payload_out", rsp_if.payload_out, want.payload_out);
         if (rsp_if.source_queue !== want.source_queue)
            report_mismatch("source_queue", rsp_if.source_queue, want.source_queue);
         if (rsp_if.from_remote !== want.from_remote)
            report_mismatch("from_remote", rsp_if.from_remote, want.from_remote);
         if (rsp_if.epoch_advanced !== want.epoch_advanced)
            report_mismatch("epoch_advanced", rsp_if.epoch_advanced,
                            want.epoch_advanced);
         if (rsp_if.epoch !== want.epoch)
            report_mismatch("epoch", rsp_if.epoch, want.epoch);
      end
   endtask

   // Monitor: requests into the model, responses against it
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid === 1'b1 && rsp_if.ready) check_result();
         if (req_if.valid && req_if.ready === 1'b1) begin
            merge_predict({req_if.operation, req_if.queue_id,
                           req_if.is_end_marker, req_if.payload});
            n_accepted++;
         end
      end
   end

   // Driver: bursts of items with random gaps between them
   always @(negedge clock) begin
      req_item_type nxt;
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_taken) begin
         if (gap_left != 0) begin
            req_if.valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (queued_requests.size() != 0) begin
            nxt = queued_requests.pop_front();
            req_if.valid         <= 1'b1;
            req_if.operation     <= nxt.operation;
            req_if.queue_id      <= nxt.queue_id;
            req_if.is_end_marker <= nxt.is_end_marker;
            req_if.payload       <= nxt.payload;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 16);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls at a rate that changes over the run, plus long holds, one
   // of them while a large batch of requests is still waiting to be sent, if none came before
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 1;
         if (rx_cycle % 256 == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pct <= 0;
               1: stall_pct <= 20;
               2: stall_pct <= 50;
               default: stall_pct <= 80;
            endcase
         end
         if (hold_left != 0) begin
            rsp_if.ready <= 1'b0;
            hold_left <= hold_left - 1;
         end else if (rx_cycle % 3000 == 500 ||
                      (long_holds == 0 && queued_requests.size() > 40)) begin
            rsp_if.ready <= 1'b0;
            hold_left <= 200;
            long_holds <= long_holds + 1;
         end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Watchdog
   initial begin
      #4_000_000;
      $display("Timeout with %0d responses outstanding", results_due.size());
      $display("Regression FAIL");
      $finish;
   end

   task automatic push_item(input logic op, input int qid, input logic mark,
                            input logic [PAYLOAD_BITS-1:0] pay);
      queued_requests.push_back({op, QW'(qid), mark, pay});
      n_issued++;
   endtask

   // Wait until every queued item is accepted and answered
   task automatic wait_quiet();
      while (n_accepted != n_issued || results_due.size() != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   function automatic logic [CSR_DW-1:0] reg_mask(input erqm_pkg::reg_index_type idx);
      case (idx)
         erqm_pkg::REG_NODE_COUNT:    return (1 << NCW) - 1;
         erqm_pkg::REG_LOCAL_NODE:    return (1 << LNW) - 1;
         erqm_pkg::REG_QUEUE_ENTRIES: return (1 << LENW) - 1;
         default:                     return '0;
      endcase
   endfunction

   // Register write, then read back
   task automatic csr_write(input erqm_pkg::reg_index_type idx, input int value);
      logic [CSR_DW-1:0] rd;
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_AW'(4 * int'(idx));
      pwdata  <= CSR_DW'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      case (idx)
         erqm_pkg::REG_NODE_COUNT:    cfg_nodes = value & reg_mask(idx);
         erqm_pkg::REG_LOCAL_NODE:    cfg_local = value & reg_mask(idx);
         erqm_pkg::REG_QUEUE_ENTRIES: cfg_len   = value & reg_mask(idx);
         default: ;
      endcase
      // read access on the same register
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      rd = prdata & reg_mask(idx);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (rd !== (CSR_DW'(value) & reg_mask(idx)))
         report_mismatch("register readback", rd, CSR_DW'(value) & reg_mask(idx));
   endtask

   // Empty every queue: pop the current one, or push a marker to move past it
   task automatic drain_queues();
      int q;
      while (queues_busy()) begin
         q = (rr_cur >= active_nodes()) ? 0 : rr_cur;
         if (ring_head[q] == ring_tail[q])
            push_item(erqm_pkg::OP_ENQUEUE, q, 1'b1, $urandom);
         push_item(erqm_pkg::OP_DEQUEUE, $urandom_range(0, 7),
                   1'($urandom_range(0, 1)), $urandom);
         wait_quiet();
      end
   endtask

   // Registers change only with every queue empty and the block idle
   task automatic apply_settings(input int nodes, input int local_id, input int len);
      drain_queues();
      wait_quiet();
      csr_write(erqm_pkg::REG_NODE_COUNT, nodes);
      csr_write(erqm_pkg::REG_LOCAL_NODE, local_id);
      csr_write(erqm_pkg::REG_QUEUE_ENTRIES, len);
      settings_used++;
   endtask

   function automatic logic [PAYLOAD_BITS-1:0] pick_payload();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // Mostly traffic to live queues, some markers, some stray queue ids
   task automatic random_items(input int count);
      int qid;
      repeat (count) begin
         if ($urandom_range(0, 99) < 45) begin
            push_item(erqm_pkg::OP_DEQUEUE, $urandom_range(0, 7),
                      1'($urandom_range(0, 1)), pick_payload());
         end else begin
            qid = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7)
                                               : $urandom_range(0, active_nodes() - 1);
            push_item(erqm_pkg::OP_ENQUEUE, qid, $urandom_range(0, 5) == 0,
                      pick_payload());
         end
      end
   endtask

   // Stimulus
   initial begin
      reset = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Two queues, ring of three: capacity two
      apply_settings(2, 1, 3);
      push_item(erqm_pkg::OP_ENQUEUE, 0, 1'b0, 32'h0000_0000);
      push_item(erqm_pkg::OP_ENQUEUE, 0, 1'b0, 32'hFFFF_FFFF);
      push_item(erqm_pkg::OP_ENQUEUE, 0, 1'b1, 32'h0000_0001);   // full
      push_item(erqm_pkg::OP_ENQUEUE, 2, 1'b0, 32'h0000_0002);   // beyond node count
      push_item(erqm_pkg::OP_ENQUEUE, 7, 1'b1, 32'hFFFF_FFFF);   // beyond node count
      push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);           // remote message
      push_item(erqm_pkg::OP_DEQUEUE, 7, 1'b1, 32'hFFFF_FFFF);
      push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);           // current empty
      push_item(erqm_pkg::OP_ENQUEUE, 0, 1'b1, 32'h1234_5678);
      push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);           // marker, to queue 1
      push_item(erqm_pkg::OP_ENQUEUE, 1, 1'b0, 32'h5A5A_A5A5);
      push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);           // local message
      push_item(erqm_pkg::OP_ENQUEUE, 1, 1'b1, 32'h0);
      push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);           // epoch closes
      push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);           // queue 0, empty
      wait_quiet();

      // Walk the current pointer to queue 5, then shrink the node count under it
      apply_settings(8, 0, 64);
      for (int q = 0; q < 5; q++) push_item(erqm_pkg::OP_ENQUEUE, q, 1'b1, $urandom);
      repeat (5) push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);
      wait_quiet();
      apply_settings(3, 2, 4);
      push_item(erqm_pkg::OP_DEQUEUE, 0, 1'b0, 32'h0);           // pointer reset to zero
      wait_quiet();

      // Random phases
      for (int p = 0; p < 7; p++) begin
         if (p != 0) apply_settings(phase_nodes[p], phase_local[p], phase_len[p]);
         random_items(65);
         wait_quiet();
      end

      while (n_accepted != n_issued || results_due.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
      if (results_due.size() != 0)
         report_mismatch("responses never delivered", results_due.size(), 0);

      $display("Checked %0d responses over %0d register settings, %0d epochs, %0d long holds",
               n_results, settings_used, epoch_ctr, long_holds);
      $display("By status: enq %0d full %0d msg %0d marker %0d empty %0d bad %0d",
               seen_status[erqm_pkg::ST_ENQUEUED], seen_status[erqm_pkg::ST_FULL],
               seen_status[erqm_pkg::ST_MESSAGE], seen_status[erqm_pkg::ST_MARKER],
               seen_status[erqm_pkg::ST_EMPTY], seen_status[erqm_pkg::ST_BAD_QUEUE]);
      if (error_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: epoch_round_robin_queue_merge.f
rtl/core/erqm_pkg.sv
rtl/core/erqm_if.sv
rtl/core/erqm_csr.sv
rtl/core/erqm_store.sv
rtl/core/erqm_ctrl.sv
rtl/core/epoch_round_robin_queue_merge.sv
tb/tb_epoch_round_robin_queue_merge.sv
